### hdl/swu_pkg.sv
`default_nettype none

package swu_pkg;

    // Sizing of the line store and the datapath.
    localparam int MAX_RADIUS  = 3;
    localparam int MAX_COLS    = 256;
    localparam int MAX_ROWS    = 4096;
    localparam int DATA_WIDTH  = 32;
    localparam int LINES       = 2 * MAX_RADIUS + 1;
    localparam int STORE_DEPTH = LINES * MAX_COLS;

    localparam int RAD_W      = 2;
    localparam int SIDE_W     = $clog2(2 * MAX_RADIUS + 2);
    localparam int ROW_W      = 12;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int LINE_W     = $clog2(LINES);
    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int ROWS_CFG_W = 13;
    localparam int COLS_CFG_W = 9;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [RAD_W-1:0]      RADIUS_RST    = 2'd1;
    localparam logic [ROWS_CFG_W-1:0] GRID_ROWS_RST = 13'd10;
    localparam logic [COLS_CFG_W-1:0] GRID_COLS_RST = 9'd10;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] pixel_value;
        logic                  frame_start;
    } t_in;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] window_value;
        logic                  window_last;
        logic [ROW_W-1:0]      center_row;
        logic [COL_W-1:0]      center_col;
    } t_out;

    typedef struct packed {
        logic [RAD_W-1:0]      radius;
        logic [ROWS_CFG_W-1:0] grid_rows;
        logic [COLS_CFG_W-1:0] grid_cols;
    } t_cfg;

    // One classified grid element, handed from the front to the back.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] pixel;
        logic [LINE_W-1:0]     wr_line;
        logic [COL_W-1:0]      wr_col;
        logic                  emit;
        logic [RAD_W-1:0]      radius;
        logic [LINE_W-1:0]     top_line;
        logic [COL_W-1:0]      left_col;
        logic [ROW_W-1:0]      center_row;
        logic [COL_W-1:0]      center_col;
    } t_job;

endpackage

`default_nettype wire

### hdl/swu_front.sv
`default_nettype none

module swu_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire swu_pkg::t_cfg i_cfg,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire swu_pkg::t_in  i_in_data,
    output logic               o_job_valid,
    input  wire logic          i_job_ready,
    output swu_pkg::t_job      o_job
);
    import swu_pkg::*;

    logic [ROW_W-1:0]      r_row, n_row;
    logic [COL_W-1:0]      r_col, n_col;
    logic [LINE_W-1:0]     r_line, n_line;

    logic [RAD_W-1:0]      w_rad;
    logic [ROWS_CFG_W-1:0] w_rows;
    logic [COLS_CFG_W-1:0] w_cols;
    logic [ROW_W-1:0]      w_row0, w_row;
    logic [COL_W-1:0]      w_col0, w_col;
    logic [LINE_W-1:0]     w_line0, w_line;
    logic [SIDE_W-1:0]     w_two_r;
    logic [LINE_W:0]       w_top_sum;
    logic                  w_accept;

    assign o_in_ready  = i_job_ready;
    assign o_job_valid = i_in_valid;
    assign w_accept    = i_in_valid && i_job_ready;

    // Clamp the configuration into its legal range.
    always_comb begin
        w_rad  = (i_cfg.radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : i_cfg.radius;
        w_rows = i_cfg.grid_rows;
        if (i_cfg.grid_rows == '0) begin
            w_rows = ROWS_CFG_W'(1);
        end else if (i_cfg.grid_rows > ROWS_CFG_W'(MAX_ROWS)) begin
            w_rows = ROWS_CFG_W'(MAX_ROWS);
        end
        w_cols = i_cfg.grid_cols;
        if (i_cfg.grid_cols == '0) begin
            w_cols = COLS_CFG_W'(1);
        end else if (i_cfg.grid_cols > COLS_CFG_W'(MAX_COLS)) begin
            w_cols = COLS_CFG_W'(MAX_COLS);
        end
    end

    // Position of this element, after frame start and wrap into the grid size.
    always_comb begin
        w_row0  = i_in_data.frame_start ? '0 : r_row;
        w_col0  = i_in_data.frame_start ? '0 : r_col;
        w_line0 = i_in_data.frame_start ? '0 : r_line;
        if ({1'b0, w_row0} >= w_rows) begin
            w_row  = '0;
            w_line = '0;
        end else begin
            w_row  = w_row0;
            w_line = w_line0;
        end
        w_col = ({1'b0, w_col0} >= w_cols) ? '0 : w_col0;
    end

    // Classify: a window is due when the element closes the window's bottom-right corner.
    always_comb begin
        w_two_r   = {w_rad, 1'b0};
        w_top_sum = {1'b0, w_line} + (LINE_W + 1)'(LINES) - (LINE_W + 1)'(w_two_r);
        o_job.pixel      = i_in_data.pixel_value;
        o_job.wr_line    = w_line;
        o_job.wr_col     = w_col;
        o_job.emit       = (w_row >= ROW_W'(w_two_r)) && (w_col >= COL_W'(w_two_r));
        o_job.radius     = w_rad;
        o_job.top_line   = (w_top_sum >= (LINE_W + 1)'(LINES))
                         ? LINE_W'(w_top_sum - (LINE_W + 1)'(LINES))
                         : LINE_W'(w_top_sum);
        o_job.left_col   = w_col - COL_W'(w_two_r);
        o_job.center_row = w_row - ROW_W'(w_rad);
        o_job.center_col = w_col - COL_W'(w_rad);
    end

    // Position of the next element.
    always_comb begin
        n_row  = w_row;
        n_col  = w_col + 1'b1;
        n_line = w_line;
        if ({1'b0, w_col} + 1'b1 >= w_cols) begin
            n_col = '0;
            if ({1'b0, w_row} + 1'b1 >= w_rows) begin
                n_row  = '0;
                n_line = '0;
            end else begin
                n_row  = w_row + 1'b1;
                n_line = (w_line == LINE_W'(LINES - 1)) ? '0 : w_line + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_line <= '0;
        end else if (w_accept) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_line <= n_line;
        end
    end

endmodule

`default_nettype wire

### hdl/swu_queue.sv
`default_nettype none

module swu_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire swu_pkg::t_job i_push_job,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output swu_pkg::t_job      o_pop_job
);
    import swu_pkg::*;

    // Two entries let the front take the next element while the back works.
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_job    = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

`default_nettype wire

### hdl/swu_back.sv
`default_nettype none

module swu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    output logic               o_job_ready,
    input  wire swu_pkg::t_job i_job,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output swu_pkg::t_out      o_out_data
);
    import swu_pkg::*;

    // Line store: one write port and one registered read port.
    logic [DATA_WIDTH-1:0] r_store [STORE_DEPTH];
    logic [DATA_WIDTH-1:0] r_mem_q;

    logic              r_written;
    logic [SIDE_W-1:0] r_k, r_h;

    logic              r_rd_v, r_rd_last, r_byp;
    logic [ROW_W-1:0]  r_rd_crow;
    logic [COL_W-1:0]  r_rd_ccol;
    logic [DATA_WIDTH-1:0] r_byp_data;

    t_out              r_ob [2];
    logic              r_ob_wp, r_ob_rp;
    logic [1:0]        r_ob_cnt;

    logic [SIDE_W-1:0] w_side_m1;
    logic              w_do_write, w_issue, w_last_el, w_pop_job, w_room, w_out_pop;
    logic [LINE_W:0]   w_line_sum;
    logic [LINE_W-1:0] w_rd_line;
    logic [COL_W-1:0]  w_rd_col;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    t_out              w_push_item;

    // Sequencing over the window elements of the job at the queue head.
    always_comb begin
        w_side_m1  = SIDE_W'({i_job.radius, 1'b0});
        w_out_pop  = o_out_valid && i_out_ready;
        w_room     = (3'({1'b0, r_ob_cnt}) + 3'(r_rd_v)) < (3'd2 + 3'(w_out_pop));
        w_do_write = i_job_valid && !r_written;
        w_issue    = i_job_valid && i_job.emit && w_room;
        w_last_el  = (r_k == w_side_m1) && (r_h == w_side_m1);
        w_pop_job  = i_job_valid && (i_job.emit ? (w_issue && w_last_el) : 1'b1);
        o_job_ready = w_pop_job;
        w_line_sum = {1'b0, i_job.top_line} + (LINE_W + 1)'(r_k);
        w_rd_line  = (w_line_sum >= (LINE_W + 1)'(LINES))
                   ? LINE_W'(w_line_sum - (LINE_W + 1)'(LINES))
                   : LINE_W'(w_line_sum);
        w_rd_col   = i_job.left_col + COL_W'(r_h);
        w_waddr    = ADDR_W'(i_job.wr_line) * ADDR_W'(MAX_COLS) + ADDR_W'(i_job.wr_col);
        w_raddr    = ADDR_W'(w_rd_line) * ADDR_W'(MAX_COLS) + ADDR_W'(w_rd_col);
    end

    // Store write and registered read.
    always_ff @(posedge i_clk) begin
        if (w_do_write) begin
            r_store[w_waddr] <= i_job.pixel;
        end
        if (w_issue) begin
            r_mem_q <= r_store[w_raddr];
        end
    end

    // Read stage: element tags and same-cycle write bypass.
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_last  <= w_last_el;
            r_rd_crow  <= i_job.center_row;
            r_rd_ccol  <= i_job.center_col;
            r_byp      <= w_do_write && (w_raddr == w_waddr);
            r_byp_data <= i_job.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= 1'b0;
            r_k       <= '0;
            r_h       <= '0;
            r_rd_v    <= 1'b0;
        end else begin
            r_rd_v <= w_issue;
            if (w_pop_job) begin
                r_written <= 1'b0;
            end else if (w_do_write) begin
                r_written <= 1'b1;
            end
            if (w_issue) begin
                if (r_h == w_side_m1) begin
                    r_h <= '0;
                    r_k <= w_last_el ? '0 : r_k + 1'b1;
                end else begin
                    r_h <= r_h + 1'b1;
                end
            end
        end
    end

    // Output buffer of two entries; credit above keeps it from overflowing.
    always_comb begin
        w_push_item.window_value = r_byp ? r_byp_data : r_mem_q;
        w_push_item.window_last  = r_rd_last;
        w_push_item.center_row   = r_rd_crow;
        w_push_item.center_col   = r_rd_ccol;
    end

    assign o_out_valid = (r_ob_cnt != 2'd0);
    assign o_out_data  = r_ob[r_ob_rp];

    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_ob[r_ob_wp] <= w_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            if (r_rd_v) begin
                r_ob_wp <= ~r_ob_wp;
            end
            if (w_out_pop) begin
                r_ob_rp <= ~r_ob_rp;
            end
            r_ob_cnt <= r_ob_cnt + {1'b0, r_rd_v} - {1'b0, w_out_pop};
        end
    end

endmodule

`default_nettype wire

### hdl/stencil_window_unroller.sv
`default_nettype none

// Sliding-window unroller for a square stencil of radius r (0..3). Grid values
// come in raster order; once the value at (i+r, j+r) arrives and the centre
// (i, j) is at least r from every border, the (2r+1)x(2r+1) window around it
// leaves row-major, window_last set on its final element and the centre
// coordinates on every element. Border centres give nothing. A front stage
// tracks the grid position and classifies each value, a two-entry queue
// decouples it from the back stage, and the back stage writes the value into a
// seven-row line store and reads the window out through its single read port,
// one element per cycle while the output buffer has room. A window-closing item
// holds the back stage for all (2r+1)^2 reads; others leave once written.
// Configuration writes go to i_cfg_we/i_cfg_idx/i_cfg_data (0 radius, 1 rows,
// 2 columns) and belong to idle periods. The line store needs no clearing.
module stencil_window_unroller (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [swu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [swu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire swu_pkg::t_in                  i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output swu_pkg::t_out                      o_out_data
);
    import swu_pkg::*;

    t_cfg r_cfg;
    t_job w_front_job, w_head_job;
    logic w_front_valid, w_front_ready, w_head_valid, w_head_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius    <= RADIUS_RST;
            r_cfg.grid_rows <= GRID_ROWS_RST;
            r_cfg.grid_cols <= GRID_COLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIUS:    r_cfg.radius    <= i_cfg_data[RAD_W-1:0];
                CFG_GRID_ROWS: r_cfg.grid_rows <= i_cfg_data[ROWS_CFG_W-1:0];
                CFG_GRID_COLS: r_cfg.grid_cols <= i_cfg_data[COLS_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    swu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (w_front_valid),
        .i_job_ready (w_front_ready),
        .o_job       (w_front_job)
    );

    swu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_job   (w_front_job),
        .o_pop_valid  (w_head_valid),
        .i_pop_ready  (w_head_ready),
        .o_pop_job    (w_head_job)
    );

    swu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_head_valid),
        .o_job_ready (w_head_ready),
        .i_job       (w_head_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

### hdl/swu_checker.sv
`default_nettype none

module swu_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire swu_pkg::t_out o_out_data
);
    import swu_pkg::*;

    // A window element offered downstream stays until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output element changed or dropped while stalled");

    // Reset leaves no window element pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // The front can take an element right after reset.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready right after reset");

    // Centre row and the last flag do not change inside a window while it is stalled.
    a_center_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready && !o_out_data.window_last
        |=> o_out_data.center_row == $past(o_out_data.center_row)
            && !o_out_data.window_last == !$past(o_out_data.window_last))
        else $error("window tag changed on a stalled element");

    // While an offered input is not taken, its ready must stay known.
    a_in_ready_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> !$isunknown(o_in_ready))
        else $error("input ready unknown");

endmodule

bind stencil_window_unroller swu_checker u_swu_checker (.*);

`default_nettype wire

### tb/stencil_window_unroller_tb.sv
`timescale 1ns / 100ps

module stencil_window_unroller_tb;

    import swu_pkg::*;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Quiet cycles in a row before the run is declared hung. The longest quiet
    // stretch of a correct run is the long receiver hold plus a config pause.
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE_CYC  = 32;

    // Mirror of the unroller: line store, position and registers, plus the
    // window elements that are still due from the block.
    class window_scoreboard;
        logic [DATA_WIDTH-1:0] line_mem [STORE_DEPTH];
        int unsigned           row_pos;
        int unsigned           col_pos;
        logic [RAD_W-1:0]      radius;
        logic [ROWS_CFG_W-1:0] grid_rows;
        logic [COLS_CFG_W-1:0] grid_cols;
        t_out                  due_elems[$];
        int                    errors;

        function new();
            radius    = RADIUS_RST;
            grid_rows = GRID_ROWS_RST;
            grid_cols = GRID_COLS_RST;
            row_pos   = 0;
            col_pos   = 0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
            case (idx)
                CFG_RADIUS:    radius = word[RAD_W-1:0];
                CFG_GRID_ROWS: grid_rows = word[ROWS_CFG_W-1:0];
                CFG_GRID_COLS: grid_cols = word[COLS_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned line_slot(int unsigned row, int unsigned col);
            return (row % LINES) * MAX_COLS + (col % MAX_COLS);
        endfunction

        function int pending();
            return due_elems.size();
        endfunction

        // Store one grid value and queue the window it completes, if any.
        function void unroll_pixel(t_in px);
            int unsigned r;
            int unsigned side;
            int unsigned n_rows;
            int unsigned n_cols;
            int unsigned top;
            int unsigned left;
            int unsigned k;
            int unsigned h;
            t_out        elem;
            r      = radius;
            side   = 2 * r + 1;
            n_rows = (grid_rows == 0) ? 1 : ((grid_rows > MAX_ROWS) ? MAX_ROWS : grid_rows);
            n_cols = (grid_cols == 0) ? 1 : ((grid_cols > MAX_COLS) ? MAX_COLS : grid_cols);

            // Frame start and out-of-range counters both restart the position.
            if (px.frame_start) begin
                row_pos = 0;
                col_pos = 0;
            end
            if (row_pos >= n_rows) row_pos = 0;
            if (col_pos >= n_cols) col_pos = 0;
            line_mem[line_slot(row_pos, col_pos)] = px.pixel_value;

            // The value at the bottom-right corner closes an interior window.
            if (row_pos >= 2 * r && col_pos >= 2 * r) begin
                top  = row_pos - 2 * r;
                left = col_pos - 2 * r;
                for (k = 0; k < side; k++) begin
                    for (h = 0; h < side; h++) begin
                        elem.window_value = line_mem[line_slot(top + k, left + h)];
                        elem.window_last  = (k == side - 1) && (h == side - 1);
                        elem.center_row   = ROW_W'(row_pos - r);
                        elem.center_col   = COL_W'(col_pos - r);
                        due_elems.insert(due_elems.size(), elem);
                    end
                end
            end

            // Advance in raster order and wrap at the end of the grid.
            if (col_pos + 1 >= n_cols) begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= n_rows) ? 0 : row_pos + 1;
            end else begin
                col_pos = col_pos + 1;
            end
        endfunction

        function void check_element(t_out got);
            t_out want;
            if (due_elems.size() == 0) begin
                $error("unexpected window element: value %h last %0d center (%0d,%0d)",
                       got.window_value, got.window_last, got.center_row, got.center_col);
                errors++;
                return;
            end
            want = due_elems.pop_front();
            if (got.window_value !== want.window_value) begin
                $error("window_value: expected %h, got %h", want.window_value, got.window_value);
                errors++;
            end
            if (got.window_last !== want.window_last) begin
                $error("window_last: expected %0d, got %0d", want.window_last, got.window_last);
                errors++;
            end
            if (got.center_row !== want.center_row) begin
                $error("center_row: expected %0d, got %0d", want.center_row, got.center_row);
                errors++;
            end
            if (got.center_col !== want.center_col) begin
                $error("center_col: expected %0d, got %0d", want.center_col, got.center_col);
                errors++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  pix_valid = 1'b0;
    logic                  pix_ready;
    t_in                   pix_data  = '0;
    logic                  win_valid;
    logic                  win_ready = 1'b0;
    t_out                  win_data;

    window_scoreboard sb = new();

    bit tail_mode     = 1'b0;
    bit tx_calm       = 1'b0;
    bit rx_calm       = 1'b0;
    bit long_hold_req = 1'b0;
    int quiet_cycles  = 0;

    stencil_window_unroller u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (pix_valid),
        .o_in_ready (pix_ready),
        .i_in_data  (pix_data),
        .o_out_valid(win_valid),
        .i_out_ready(win_ready),
        .o_out_data (win_data)
    );

    always #5 clk = ~clk;

    // Sample both channels at the rising edge and watch for a hung block.
    always @(posedge clk) begin
        if (rst_n) begin
            if (pix_valid && pix_ready) sb.unroll_pixel(pix_data);
            if (win_valid && win_ready) sb.check_element(win_data);
            if ((pix_valid && pix_ready) || (win_valid && win_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, calm stretches and one long hold.
    initial begin : result_sink
        int unsigned hold;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                win_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end else if (!tail_mode && !rx_calm && $urandom_range(0, 3) == 0) begin
                win_ready <= 1'b0;
                hold = $urandom_range(1, 11);
                repeat (hold - 1) @(negedge clk);
            end else begin
                win_ready <= 1'b1;
            end
        end
    end

    // One register write per cycle; the write enable drops after the last one.
    task put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= word;
        sb.write_reg(idx, word);
        @(negedge clk);
    endtask

    task load_config(input logic [CFG_DATA_W-1:0] rad_word,
                     input logic [CFG_DATA_W-1:0] rows_word,
                     input logic [CFG_DATA_W-1:0] cols_word);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        put_reg(CFG_RADIUS, rad_word);
        put_reg(CFG_GRID_ROWS, rows_word);
        put_reg(CFG_GRID_COLS, cols_word);
        put_reg(CFG_SPARE, junk);
        cfg_we <= 1'b0;
    endtask

    // Offer one grid value, maybe after an idle burst, and wait for the transfer.
    task offer_pixel(input t_in px);
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
        if (!tail_mode && !tx_calm && $urandom_range(0, 3) == 0) begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        @(posedge clk);
        while (!pix_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Random grid values; a fresh stream opens a new grid, a noisy one may
    // restart the grid at random points.
    task stream_pixels(input int unsigned count, input bit fresh, input bit noisy);
        t_in px;
        for (int unsigned i = 0; i < count; i++) begin
            px.pixel_value = $urandom;
            px.frame_start = (fresh && i == 0) || (noisy && $urandom_range(0, 31) == 0);
            offer_pixel(px);
        end
    endtask

    // Stop offering, wait for every due element, then let the pipeline empty.
    task settle();
        pix_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    initial begin : stimulus
        t_in                   px;
        logic [CFG_DATA_W-1:0] rad_word;
        logic [CFG_DATA_W-1:0] rows_word;
        logic [CFG_DATA_W-1:0] cols_word;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration (10x10, radius 1): zero, all ones, walking one.
        for (int i = 0; i < 24; i++) begin
            px.pixel_value = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : 32'h1 << (i - 2);
            px.frame_start = (i == 0);
            offer_pixel(px);
        end
        settle();

        // Zero rows and columns clamp to a 1x1 grid; radius 0 echoes each value.
        load_config(13'h1FFC, 13'h0000, 13'h1E00);
        px = '{pixel_value: 32'h0, frame_start: 1'b1};
        offer_pixel(px);
        px = '{pixel_value: 32'hFFFF_FFFF, frame_start: 1'b0};
        offer_pixel(px);
        px = '{pixel_value: 32'hA5A5_A5A5, frame_start: 1'b1};
        offer_pixel(px);
        settle();

        // Window taller than the grid: nothing comes out.
        load_config(13'd2, 13'd3, 13'd9);
        stream_pixels(6, 1'b1, 1'b0);
        settle();

        // Small grid that wraps around without a frame start.
        load_config(13'd1, 13'd3, 13'd3);
        stream_pixels(21, 1'b1, 1'b0);
        settle();

        // Largest radius; the receiver holds off while windows are due.
        load_config(13'd3, 13'd8, 13'd8);
        stream_pixels(54, 1'b1, 1'b0);
        long_hold_req = 1'b1;
        stream_pixels(10, 1'b0, 1'b0);
        settle();

        // Radius change in the middle of a grid takes effect at once.
        load_config(13'd1, 13'd12, 13'd6);
        stream_pixels(20, 1'b1, 1'b0);
        settle();
        load_config(13'h0AAA, 13'd12, 13'd6);
        stream_pixels(30, 1'b0, 1'b1);
        settle();

        // Oversized rows and columns clamp to the maximum; part of a wide line.
        load_config(13'h1FFC, 13'h1FFF, 13'h1FFF);
        stream_pixels(64, 1'b1, 1'b0);
        settle();

        // Random small grids with random radius and junk in unused bits.
        repeat (5) begin
            rad_word        = CFG_DATA_W'($urandom);
            rows_word       = CFG_DATA_W'($urandom_range(0, 9));
            cols_word       = CFG_DATA_W'($urandom);
            cols_word[8:0]  = COLS_CFG_W'($urandom_range(0, 9));
            load_config(rad_word, rows_word, cols_word);
            stream_pixels($urandom_range(12, 30), 1'b1, 1'b1);
            settle();
        end

        // Last stretch at full rate on both sides.
        tail_mode = 1'b1;
        load_config(13'd1, 13'd6, 13'd7);
        stream_pixels(30, 1'b1, 1'b0);
        settle();

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
hdl/swu_pkg.sv
hdl/swu_front.sv
hdl/swu_queue.sv
hdl/swu_back.sv
hdl/stencil_window_unroller.sv
hdl/swu_checker.sv
tb/stencil_window_unroller_tb.sv
